### rtl/dvtu_pkg.sv
package dvtu_pkg;

  localparam int NUM_NODES = 4;
  localparam int NODE_W    = 2;
  localparam int COST_BITS = 16;
  localparam int ADDR_W    = 2 * NODE_W;
  localparam int DEPTH     = NUM_NODES * NUM_NODES;

  typedef logic [COST_BITS-1:0] cost_t;
  typedef logic [NODE_W-1:0]    node_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_PACKET = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_DEST = 2'd1;
  localparam logic [1:0] ST_SRC_SELF = 2'd2;

  typedef struct packed {
    logic  func;
    node_t source_node;
    node_t dest_node;
    cost_t cost_0;
    cost_t cost_1;
    cost_t cost_2;
    cost_t cost_3;
  } dvtu_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       changed;
    logic       symmetric;
    cost_t      own_col_0;
    cost_t      own_col_1;
    cost_t      own_col_2;
    cost_t      own_col_3;
  } dvtu_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_ROW_RD,
    S_ROW_CMP,
    S_RLX_RD0,
    S_RLX_RD1,
    S_RLX_CMP,
    S_SYM_RD,
    S_SYM_CMP,
    S_OUT_RD,
    S_OUT_CAP
  } state_t;

endpackage

### rtl/distance_vector_table_update.sv
// channel   | handshake            | payload
// ----------+----------------------+------------------------------
// input     | start / busy         | in_item  (func, nodes, costs)
// result    | out_valid (1 cycle)  | out_result (status, flags, own column)
// config    | cfg_we               | cfg_wdata (own_node)
//
// the matrix sits in two mirrored 16x16-bit rams (same writes, two read ports)
// load: writes the row (S_LOAD), then reads out the own column and gives the result
// packet: row compare (S_ROW_RD, S_ROW_CMP per entry), relax (S_RLX_RD0, S_RLX_RD1,
//   S_RLX_CMP per entry), symmetry pass (S_SYM_RD, S_SYM_CMP per entry, ends at the first asymmetry), readout
// rejected packet: readout only; busy stays high until the result strobe
// reset clears control and own_node only; the matrix is undefined until loaded
module distance_vector_table_update (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dvtu_pkg::dvtu_in_t  in_item,
  output logic                out_valid,
  output dvtu_pkg::dvtu_out_t out_result,
  input  logic                cfg_we,
  input  dvtu_pkg::node_t     cfg_wdata
);

  import dvtu_pkg::*;

  localparam node_t LAST_NODE = node_t'(NUM_NODES - 1);
  localparam node_t LAST_PAIR = node_t'(NUM_NODES - 2);

  state_t     state_r, state_nxt;
  dvtu_in_t   item_r, item_nxt;
  node_t      own_node_r;
  node_t      i_r, i_nxt, j_r, j_nxt;
  logic [COST_BITS:0] sum_r, sum_nxt;
  logic [1:0] status_r, status_nxt;
  logic       changed_r, changed_nxt;
  logic       sym_r, sym_nxt;
  cost_t      col_r [NUM_NODES];
  cost_t      col_nxt [NUM_NODES];
  logic       out_valid_r, out_valid_nxt;

  cost_t      cost_in [NUM_NODES];
  logic       we;
  addr_t      waddr, raddr_a, raddr_b;
  cost_t      wdata, rdata_a, rdata_b;
  logic       i_last, j_last, step_last, sym_less;

  assign cost_in[0] = item_r.cost_0;
  assign cost_in[1] = item_r.cost_1;
  assign cost_in[2] = item_r.cost_2;
  assign cost_in[3] = item_r.cost_3;

  assign i_last    = (i_r == LAST_NODE);
  assign j_last    = (j_r == LAST_NODE);
  assign step_last = i_last && j_last;
  assign sym_less  = (rdata_a < rdata_b);

  // two copies so every step can read two entries at once
  dvtu_ram #(.WIDTH(COST_BITS), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  dvtu_ram #(.WIDTH(COST_BITS), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_item.func == FUNC_LOAD) begin
            state_nxt = S_LOAD;
          end else if (in_item.dest_node != own_node_r ||
                       in_item.source_node == own_node_r) begin
            state_nxt = S_OUT_RD;
          end else begin
            state_nxt = S_ROW_RD;
          end
        end
      end
      S_LOAD:    state_nxt = j_last ? S_OUT_RD : S_LOAD;
      S_ROW_RD:  state_nxt = S_ROW_CMP;
      S_ROW_CMP: state_nxt = j_last ? S_RLX_RD0 : S_ROW_RD;
      S_RLX_RD0: state_nxt = S_RLX_RD1;
      S_RLX_RD1: state_nxt = S_RLX_CMP;
      S_RLX_CMP: state_nxt = step_last ? S_SYM_RD : S_RLX_RD0;
      S_SYM_RD:  state_nxt = S_SYM_CMP;
      S_SYM_CMP: state_nxt = (sym_less || step_last) ? S_OUT_RD : S_SYM_RD;
      S_OUT_RD:  state_nxt = S_OUT_CAP;
      S_OUT_CAP: state_nxt = (i_r == LAST_PAIR) ? S_IDLE : S_OUT_RD;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    item_nxt      = item_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    sum_nxt       = sum_r;
    status_nxt    = status_r;
    changed_nxt   = changed_r;
    sym_nxt       = sym_r;
    col_nxt       = col_r;
    out_valid_nxt = 1'b0;
    we            = 1'b0;
    waddr         = {i_r, j_r};
    wdata         = rdata_b;
    raddr_a       = {i_r, j_r};
    raddr_b       = {j_r, i_r};

    // advance i,j in row-major order over the matrix
    if (state_r == S_LOAD || state_r == S_ROW_CMP || state_r == S_RLX_CMP ||
        state_r == S_SYM_CMP) begin
      j_nxt = j_last ? '0 : node_t'(j_r + 1'b1);
      if (j_last) begin
        i_nxt = i_last ? '0 : node_t'(i_r + 1'b1);
      end
    end

    case (state_r)
      S_IDLE: begin
        i_nxt = '0;
        j_nxt = '0;
        if (start) begin
          item_nxt    = in_item;
          changed_nxt = 1'b0;
          sym_nxt     = 1'b0;
          if (in_item.func == FUNC_LOAD) begin
            status_nxt = ST_OK;
          end else if (in_item.dest_node != own_node_r) begin
            status_nxt = ST_BAD_DEST;
          end else if (in_item.source_node == own_node_r) begin
            status_nxt = ST_SRC_SELF;
          end else begin
            status_nxt = ST_OK;
          end
        end
      end
      S_LOAD: begin
        we    = 1'b1;
        waddr = {item_r.source_node, j_r};
        wdata = cost_in[j_r];
        i_nxt = '0;
      end
      S_ROW_RD: begin
        raddr_a = {item_r.source_node, j_r};
      end
      S_ROW_CMP: begin
        i_nxt = '0;
        if (cost_in[j_r] != rdata_a) begin
          changed_nxt = 1'b1;
        end
        if (cost_in[j_r] < rdata_a) begin
          we    = 1'b1;
          waddr = {item_r.source_node, j_r};
          wdata = cost_in[j_r];
        end
      end
      S_RLX_RD0: begin
        raddr_a = {i_r, j_r};
        raddr_b = {j_r, own_node_r};
      end
      S_RLX_RD1: begin
        raddr_a = {i_r, own_node_r};
        sum_nxt = {1'b0, rdata_a} + {1'b0, rdata_b};
      end
      S_RLX_CMP: begin
        // sum is one bit wider so it never wraps below the entry
        if (sum_r < {1'b0, rdata_a}) begin
          we    = 1'b1;
          waddr = {i_r, own_node_r};
          wdata = sum_r[COST_BITS-1:0];
        end
      end
      S_SYM_RD: begin
        raddr_a = {i_r, j_r};
        raddr_b = {j_r, i_r};
      end
      S_SYM_CMP: begin
        if (rdata_a > rdata_b) begin
          we    = 1'b1;
          waddr = {i_r, j_r};
          wdata = rdata_b;
        end
        if (sym_less) begin
          sym_nxt = 1'b0;
          i_nxt   = '0;
        end else if (step_last) begin
          sym_nxt = 1'b1;
        end
      end
      S_OUT_RD: begin
        raddr_a = {i_r, own_node_r};
        raddr_b = {node_t'(i_r | node_t'(1)), own_node_r};
      end
      S_OUT_CAP: begin
        col_nxt[i_r]                     = rdata_a;
        col_nxt[node_t'(i_r | node_t'(1))] = rdata_b;
        if (i_r == LAST_PAIR) begin
          out_valid_nxt = 1'b1;
          i_nxt         = '0;
        end else begin
          i_nxt = node_t'(i_r + node_t'(2));
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      own_node_r  <= '0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      if (cfg_we) begin
        own_node_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    sum_r     <= sum_nxt;
    status_r  <= status_nxt;
    changed_r <= changed_nxt;
    sym_r     <= sym_nxt;
    col_r     <= col_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  assign out_result.status    = status_r;
  assign out_result.changed   = changed_r;
  assign out_result.symmetric = sym_r;
  assign out_result.own_col_0 = col_r[0];
  assign out_result.own_col_1 = col_r[1];
  assign out_result.own_col_2 = col_r[2];
  assign out_result.own_col_3 = col_r[3];

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_result_after_readout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_OUT_CAP && state_r == S_IDLE))
    else $error("result strobe outside readout end");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_LOAD || state_r == S_ROW_CMP ||
            state_r == S_RLX_CMP || state_r == S_SYM_CMP))
    else $error("matrix written outside an update step");

  a_reject_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status_r != ST_OK) |-> (!changed_r && !sym_r))
    else $error("rejected packet reported flags");

  a_reject_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT_RD || state_r == S_OUT_CAP) |-> !we)
    else $error("write during readout");

endmodule

### rtl/dvtu_ram.sv
module dvtu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### dv/tb_distance_vector_table_update.sv
module tb_distance_vector_table_update;
  import dvtu_pkg::*;

  typedef struct {
    dvtu_out_t  rpt;
    logic [3:0] known;
  } due_rpt_t;

  typedef struct {
    bit        is_cfg;
    node_t     cfg_val;
    dvtu_in_t  item;
    bit        typed;
    dvtu_out_t rpt;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  dvtu_in_t  in_item;
  logic      out_valid;
  dvtu_out_t out_result;
  logic      cfg_we;
  node_t     cfg_wdata;

  // shadow copy of the routing table and of own_node
  cost_t     route_tbl [NUM_NODES][NUM_NODES];
  bit        row_loaded [NUM_NODES];
  node_t     my_node;

  due_rpt_t  due_reports[$];
  stim_row_t dir_tbl[$];
  int        err_cnt = 0;
  int        burst_left = 0;

  distance_vector_table_update dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic dvtu_in_t mk_item(logic f, node_t s, node_t d,
                                       cost_t c0, cost_t c1, cost_t c2, cost_t c3);
    dvtu_in_t it;
    it.func        = f;
    it.source_node = s;
    it.dest_node   = d;
    it.cost_0      = c0;
    it.cost_1      = c1;
    it.cost_2      = c2;
    it.cost_3      = c3;
    return it;
  endfunction

  // row update, column relaxation and symmetry pass on the shadow table
  function automatic due_rpt_t apply_route_item(dvtu_in_t it);
    due_rpt_t           d;
    cost_t              vec [NUM_NODES];
    logic [COST_BITS:0] via;
    int                 s;
    int                 c;
    bit                 sym;
    vec[0] = it.cost_0;
    vec[1] = it.cost_1;
    vec[2] = it.cost_2;
    vec[3] = it.cost_3;
    s = int'(it.source_node);
    c = int'(my_node);
    d.rpt = '0;
    if (it.func == FUNC_LOAD) begin
      for (int k = 0; k < NUM_NODES; k++) route_tbl[s][k] = vec[k];
      row_loaded[s] = 1'b1;
    end else if (it.dest_node != my_node) begin
      d.rpt.status = ST_BAD_DEST;
    end else if (it.source_node == my_node) begin
      d.rpt.status = ST_SRC_SELF;
    end else begin
      for (int k = 0; k < NUM_NODES; k++) begin
        if (vec[k] != route_tbl[s][k]) d.rpt.changed = 1'b1;
        if (vec[k] < route_tbl[s][k]) route_tbl[s][k] = vec[k];
      end
      for (int i = 0; i < NUM_NODES; i++) begin
        for (int j = 0; j < NUM_NODES; j++) begin
          // sum kept one bit wider so it never wraps
          via = {1'b0, route_tbl[i][j]} + route_tbl[j][c];
          if (via < {1'b0, route_tbl[i][c]}) route_tbl[i][c] = via[COST_BITS-1:0];
        end
      end
      sym = 1'b1;
      for (int i = 0; i < NUM_NODES && sym; i++) begin
        for (int j = 0; j < NUM_NODES && sym; j++) begin
          if (route_tbl[i][j] > route_tbl[j][i]) route_tbl[i][j] = route_tbl[j][i];
          else if (route_tbl[i][j] < route_tbl[j][i]) sym = 1'b0;
        end
      end
      d.rpt.symmetric = sym;
    end
    d.rpt.own_col_0 = route_tbl[0][c];
    d.rpt.own_col_1 = route_tbl[1][c];
    d.rpt.own_col_2 = route_tbl[2][c];
    d.rpt.own_col_3 = route_tbl[3][c];
    // rows not loaded yet hold nothing defined
    for (int i = 0; i < NUM_NODES; i++) d.known[i] = row_loaded[i];
    return d;
  endfunction

  function automatic stim_row_t ld_row(node_t s, node_t d,
                                       cost_t c0, cost_t c1, cost_t c2, cost_t c3,
                                       cost_t e0, cost_t e1, cost_t e2, cost_t e3);
    stim_row_t r;
    r = '{default: '0};
    r.item  = mk_item(FUNC_LOAD, s, d, c0, c1, c2, c3);
    r.typed = 1'b1;
    r.rpt   = '{status: ST_OK, changed: 1'b0, symmetric: 1'b0,
                own_col_0: e0, own_col_1: e1, own_col_2: e2, own_col_3: e3};
    return r;
  endfunction

  function automatic stim_row_t rj_row(node_t s, node_t d, logic [1:0] st,
                                       cost_t e0, cost_t e1, cost_t e2, cost_t e3);
    stim_row_t r;
    r = '{default: '0};
    r.item  = mk_item(FUNC_PACKET, s, d, 16'h1234, 16'h0, 16'hffff, 16'h8001);
    r.typed = 1'b1;
    r.rpt   = '{status: st, changed: 1'b0, symmetric: 1'b0,
                own_col_0: e0, own_col_1: e1, own_col_2: e2, own_col_3: e3};
    return r;
  endfunction

  function automatic stim_row_t pk_row(logic f, node_t s, node_t d,
                                       cost_t c0, cost_t c1, cost_t c2, cost_t c3);
    stim_row_t r;
    r = '{default: '0};
    r.item = mk_item(f, s, d, c0, c1, c2, c3);
    return r;
  endfunction

  function automatic stim_row_t cfg_row(node_t v);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg  = 1'b1;
    r.cfg_val = v;
    return r;
  endfunction

  function automatic cost_t rand_cost();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return cost_t'($urandom_range(0, 40));
      default: return cost_t'($urandom);
    endcase
  endfunction

  task automatic send_item(dvtu_in_t it, bit typed, dvtu_out_t typed_rpt);
    due_rpt_t d;
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    d = apply_route_item(it);
    if (typed) d.rpt = typed_rpt;
    due_reports.push_back(d);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 110)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic write_own_node(node_t v);
    start <= 1'b0;
    while (due_reports.size() != 0 || busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    my_node = v;
  endtask

  task automatic run_phase(int n_items);
    cost_t m [NUM_NODES][NUM_NODES];
    cost_t v [NUM_NODES];
    node_t src;
    node_t dst;
    int    kind;
    int    sent;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        // fresh symmetric table with mostly small costs, loaded row by row
        for (int i = 0; i < NUM_NODES; i++) begin
          m[i][i] = ($urandom_range(0, 7) == 0) ? rand_cost() : '0;
          for (int j = i + 1; j < NUM_NODES; j++) begin
            m[i][j] = ($urandom_range(0, 7) == 0) ? rand_cost()
                                                  : cost_t'($urandom_range(1, 30));
            m[j][i] = m[i][j];
          end
        end
        for (int r = 0; r < NUM_NODES; r++) begin
          send_item(mk_item(FUNC_LOAD, node_t'(r), node_t'($urandom),
                            m[r][0], m[r][1], m[r][2], m[r][3]), 1'b0, '0);
        end
        sent += NUM_NODES;
      end else if (kind < 18) begin
        send_item(mk_item(FUNC_LOAD, node_t'($urandom), node_t'($urandom),
                          rand_cost(), rand_cost(), rand_cost(), rand_cost()), 1'b0, '0);
        sent++;
      end else if (kind < 30) begin
        if ($urandom_range(0, 1)) begin
          dst = node_t'(my_node + $urandom_range(1, 3));
          src = node_t'($urandom);
        end else begin
          dst = my_node;
          src = my_node;
        end
        send_item(mk_item(FUNC_PACKET, src, dst,
                          rand_cost(), rand_cost(), rand_cost(), rand_cost()), 1'b0, '0);
        sent++;
      end else begin
        src = node_t'(my_node + $urandom_range(1, 3));
        case ($urandom_range(0, 3))
          0: for (int k = 0; k < NUM_NODES; k++) v[k] = route_tbl[src][k];
          1: for (int k = 0; k < NUM_NODES; k++) begin
            v[k] = route_tbl[src][k];
            if ($urandom_range(0, 1)) v[k] = cost_t'($urandom_range(0, v[k]));
          end
          2: for (int k = 0; k < NUM_NODES; k++) v[k] = cost_t'($urandom_range(0, 30));
          default: for (int k = 0; k < NUM_NODES; k++) v[k] = rand_cost();
        endcase
        send_item(mk_item(FUNC_PACKET, src, my_node, v[0], v[1], v[2], v[3]),
                  1'b0, '0);
        sent++;
      end
    end
  endtask

  function automatic void chk(string name, logic [15:0] want, logic [15:0] got, bit on);
    if (on && got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin : rpt_check
    due_rpt_t d;
    if (rst_n && out_valid) begin
      if (due_reports.size() == 0) begin
        $error("report with none outstanding: %p", out_result);
        err_cnt++;
      end else begin
        d = due_reports.pop_front();
        chk("status", d.rpt.status, out_result.status, 1'b1);
        chk("changed", d.rpt.changed, out_result.changed, 1'b1);
        chk("symmetric", d.rpt.symmetric, out_result.symmetric, 1'b1);
        chk("own_col_0", d.rpt.own_col_0, out_result.own_col_0, d.known[0]);
        chk("own_col_1", d.rpt.own_col_1, out_result.own_col_1, d.known[1]);
        chk("own_col_2", d.rpt.own_col_2, out_result.own_col_2, d.known[2]);
        chk("own_col_3", d.rpt.own_col_3, out_result.own_col_3, d.known[3]);
      end
    end
  end

  initial begin
    #18_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    my_node   = '0;
    foreach (route_tbl[i, j]) route_tbl[i][j] = '0;
    foreach (row_loaded[i]) row_loaded[i] = 1'b0;

    // own_node is 0 out of reset; the first four rows fill the table
    dir_tbl.push_back(ld_row(2'd0, 2'd3, 16'h0000, 16'd5, 16'hffff, 16'd9,
                             16'd0, 16'd0, 16'd0, 16'd0));
    dir_tbl.push_back(ld_row(2'd1, 2'd0, 16'd5, 16'h0000, 16'd3, 16'hffff,
                             16'd0, 16'd5, 16'd0, 16'd0));
    dir_tbl.push_back(ld_row(2'd2, 2'd1, 16'hffff, 16'd3, 16'h0000, 16'd2,
                             16'd0, 16'd5, 16'hffff, 16'd0));
    dir_tbl.push_back(ld_row(2'd3, 2'd2, 16'd9, 16'hffff, 16'd2, 16'h0000,
                             16'd0, 16'd5, 16'hffff, 16'd9));
    dir_tbl.push_back(rj_row(2'd1, 2'd2, ST_BAD_DEST, 16'd0, 16'd5, 16'hffff, 16'd9));
    dir_tbl.push_back(rj_row(2'd0, 2'd0, ST_SRC_SELF, 16'd0, 16'd5, 16'hffff, 16'd9));
    // both checks fail: the destination check wins
    dir_tbl.push_back(rj_row(2'd0, 2'd3, ST_BAD_DEST, 16'd0, 16'd5, 16'hffff, 16'd9));
    dir_tbl.push_back(pk_row(FUNC_PACKET, 2'd1, 2'd0, 16'd5, 16'd0, 16'd3, 16'hffff));
    dir_tbl.push_back(pk_row(FUNC_PACKET, 2'd2, 2'd0, 16'hffff, 16'hffff, 16'hffff,
                             16'hffff));
    dir_tbl.push_back(pk_row(FUNC_PACKET, 2'd3, 2'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    dir_tbl.push_back(pk_row(FUNC_PACKET, 2'd1, 2'd0, 16'hffff, 16'd0, 16'hffff, 16'd1));
    dir_tbl.push_back(pk_row(FUNC_PACKET, 2'd2, 2'd0, 16'd1, 16'hffff, 16'd0, 16'hffff));
    dir_tbl.push_back(cfg_row(2'd3));
    dir_tbl.push_back(pk_row(FUNC_PACKET, 2'd3, 2'd3, 16'd1, 16'd1, 16'd1, 16'd1));
    dir_tbl.push_back(pk_row(FUNC_PACKET, 2'd0, 2'd1, 16'd1, 16'd1, 16'd1, 16'd1));
    dir_tbl.push_back(pk_row(FUNC_LOAD, 2'd0, 2'd2, 16'hffff, 16'hffff, 16'hffff,
                             16'hffff));
    dir_tbl.push_back(pk_row(FUNC_PACKET, 2'd0, 2'd3, 16'd0, 16'd7, 16'd7, 16'd7));
    dir_tbl.push_back(pk_row(FUNC_PACKET, 2'd1, 2'd3, 16'hffff, 16'hffff, 16'hffff,
                             16'hffff));
    dir_tbl.push_back(pk_row(FUNC_PACKET, 2'd2, 2'd3, 16'd3, 16'd3, 16'd3, 16'd0));
    dir_tbl.push_back(pk_row(FUNC_LOAD, 2'd3, 2'd0, 16'h8000, 16'h7fff, 16'h00ff,
                             16'hff00));
    dir_tbl.push_back(pk_row(FUNC_PACKET, 2'd0, 2'd3, 16'h5555, 16'haaaa, 16'h0f0f,
                             16'hf0f0));
    dir_tbl.push_back(cfg_row(2'd0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[r]) begin
      if (dir_tbl[r].is_cfg) write_own_node(dir_tbl[r].cfg_val);
      else send_item(dir_tbl[r].item, dir_tbl[r].typed, dir_tbl[r].rpt);
    end

    for (int p = 0; p < 9; p++) begin
      write_own_node(p == 0 ? 2'd3 : p == 1 ? 2'd0 : node_t'($urandom_range(0, 3)));
      run_phase(100);
    end

    start <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/dvtu_pkg.sv
rtl/dvtu_ram.sv
rtl/distance_vector_table_update.sv
dv/tb_distance_vector_table_update.sv
